### rtl/core/wtbs_pkg.sv
`default_nettype none
package wtbs_pkg;

    localparam int TEMP_W  = 20;
    localparam int FLUX_W  = 32;
    localparam int K_W     = 16;
    localparam int ITER_W  = 6;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 20;

    localparam logic [TEMP_W-1:0] TEMP_MAX = '1;

    // register indexes of the configuration port
    localparam logic [CIDX_W-1:0] REG_CONDUCTIVITY = 3'd0;
    localparam logic [CIDX_W-1:0] REG_THICKNESS    = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TUBE_TEMP    = 3'd2;
    localparam logic [CIDX_W-1:0] REG_MAX_TEMP     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_MIN_TEMP     = 3'd4;

    // sigma * 16 * 2^36, truncated
    localparam logic [15:0] RAD_K      = 16'd62342;
    localparam logic [16:0] COND_SCALE = 17'd125000;
    localparam logic [9:0]  INIT_TOL   = 10'd1000;
    localparam logic [16:0] LOOP_TOL   = 17'd100000;

    typedef struct packed {
        logic [K_W-1:0]    conductivity;
        logic [TEMP_W-1:0] wall_thickness_um;
        logic [TEMP_W-1:0] tube_side_temp;
        logic [TEMP_W-1:0] max_wall_temp;
        logic [TEMP_W-1:0] min_wall_temp;
    } cfg_t;

    typedef struct packed {
        logic signed [FLUX_W-1:0] flux;
        logic [TEMP_W-1:0]        temp;
    } item_t;

endpackage
`default_nettype wire

### rtl/core/wtbs_fifo.sv
`default_nettype none
module wtbs_fifo (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  wr_en,
    input  wire  wtbs_pkg::item_t wr_data,
    output logic                 full,
    input  wire                  rd_en,
    output wtbs_pkg::item_t      rd_data,
    output logic                 empty
);
    import wtbs_pkg::*;

    item_t      mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign rd_data = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (wr_en) wptr_reg <= ~wptr_reg;
            if (rd_en) rptr_reg <= ~rptr_reg;
            if (wr_en && !rd_en) count_reg <= count_reg + 2'd1;
            else if (rd_en && !wr_en) count_reg <= count_reg - 2'd1;
        end
    end
endmodule
`default_nettype wire

### rtl/core/wtbs_eval.sv
`default_nettype none
module wtbs_eval (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  wtbs_pkg::cfg_t             cfg,
    input  wire                              start,
    input  wire  signed [wtbs_pkg::FLUX_W-1:0] flux,
    input  wire  [wtbs_pkg::TEMP_W-1:0]      temp,
    output logic                             done,
    output logic [wtbs_pkg::TEMP_W-1:0]      result
);
    import wtbs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_P, ST_RAD, ST_NET, ST_MUL, ST_SAT, ST_DIV, ST_ADD
    } state_t;

    state_t             state_reg;
    logic [TEMP_W-1:0]  t_reg;
    logic [31:0]        s_reg;
    logic [39:0]        p_reg;
    logic [27:0]        rad_reg;
    logic [30:0]        net_reg;
    logic [59:0]        num_reg;
    logic [32:0]        div_reg;
    logic [52:0]        rem_reg, dsh_reg;
    logic [TEMP_W-1:0]  q_reg, dt_reg;
    logic [4:0]         cnt_reg;

    logic [K_W-1:0]     k_eff;
    logic [39:0]        tsq;
    logic [63:0]        ssq;
    logic [55:0]        radp;
    logic signed [33:0] net_full;
    logic [50:0]        nt;
    logic               ge;
    logic [TEMP_W:0]    sum;

    assign k_eff    = (cfg.conductivity == '0) ? K_W'(1) : cfg.conductivity;
    assign tsq      = 40'(t_reg) * 40'(t_reg);
    assign ssq      = 64'(s_reg) * 64'(s_reg);
    assign radp     = 56'(p_reg) * 56'(RAD_K);
    assign net_full = 34'(flux) - $signed({6'b0, rad_reg});
    assign nt       = 51'(net_reg) * 51'(cfg.wall_thickness_um);
    assign ge       = rem_reg >= dsh_reg;
    assign sum      = {1'b0, cfg.tube_side_temp} + {1'b0, dt_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done      <= 1'b0;
        end else begin
            done <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        t_reg     <= temp;
                        div_reg   <= 33'(COND_SCALE) * 33'(k_eff);
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    s_reg     <= tsq[39:8];
                    state_reg <= ST_P;
                end
                ST_P: begin
                    p_reg     <= ssq[63:24];
                    state_reg <= ST_RAD;
                end
                ST_RAD: begin
                    rad_reg   <= radp[55:28];
                    state_reg <= ST_NET;
                end
                ST_NET: begin
                    net_reg   <= net_full[33] ? '0 : net_full[30:0];
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    num_reg   <= {nt, 9'b0};
                    state_reg <= ST_SAT;
                end
                ST_SAT: begin
                    // quotient of 2^20 or more saturates
                    if (num_reg >= {7'b0, div_reg, 20'b0}) begin
                        dt_reg    <= TEMP_MAX;
                        state_reg <= ST_ADD;
                    end else begin
                        rem_reg   <= num_reg[52:0];
                        dsh_reg   <= {1'b0, div_reg, 19'b0};
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (ge) rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[TEMP_W-2:0], ge};
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(TEMP_W - 1)) begin
                        dt_reg    <= {q_reg[TEMP_W-2:0], ge};
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    result    <= sum[TEMP_W] ? TEMP_MAX : sum[TEMP_W-1:0];
                    done      <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/wtbs_engine.sv
`default_nettype none
module wtbs_engine #(
    parameter int MAX_ITERATIONS = 50
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  wtbs_pkg::cfg_t             cfg,
    input  wire                              q_empty,
    input  wire  wtbs_pkg::item_t            q_data,
    output logic                             q_pop,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [wtbs_pkg::TEMP_W-1:0]      m_new_temp,
    output logic [wtbs_pkg::ITER_W-1:0]      m_iterations_used,
    output logic                             m_hit_limit
);
    import wtbs_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_WAIT0, ST_STEP, ST_WAITM, ST_OUT} state_t;

    state_t                   state_reg;
    logic signed [FLUX_W-1:0] flux_reg;
    logic [TEMP_W-1:0]        t0_reg, hi_reg, lo_reg, mid_reg, res_reg;
    logic [ITER_W-1:0]        num_reg;
    logic                     hit_reg;
    logic                     ev_start;
    logic [TEMP_W-1:0]        ev_temp, ev_res;
    logic                     ev_done;
    logic                     out_load;

    logic [TEMP_W-1:0] t1, hi0, lo0, gap0, hi_n, lo_n, gap_n;
    logic [TEMP_W:0]   mid_sum;
    logic [29:0]       init_lhs;
    logic [36:0]       loop_lhs;
    logic              unconv;

    wtbs_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .start   (ev_start),
        .flux    (flux_reg),
        .temp    (ev_temp),
        .done    (ev_done),
        .result  (ev_res)
    );

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign ev_start = (state_reg == ST_WAIT0 && num_reg == '1) || (state_reg == ST_STEP);
    assign ev_temp  = (state_reg == ST_STEP) ? mid_sum[TEMP_W:1] : t0_reg;
    assign out_load = (state_reg == ST_OUT) && (!m_valid || m_ready);

    assign t1  = ev_res;
    always_comb begin
        if (t1 < t0_reg) begin
            hi0 = (t0_reg > cfg.max_wall_temp) ? cfg.max_wall_temp : t0_reg;
            lo0 = (t1 < cfg.min_wall_temp) ? cfg.min_wall_temp : t1;
        end else begin
            hi0 = (t1 > cfg.max_wall_temp) ? cfg.max_wall_temp : t1;
            lo0 = (t0_reg < cfg.min_wall_temp) ? cfg.min_wall_temp : t0_reg;
        end
    end
    assign gap0     = (t0_reg > t1) ? t0_reg - t1 : t1 - t0_reg;
    assign init_lhs = 30'(gap0) * 30'(INIT_TOL);

    assign mid_sum  = {1'b0, hi_reg} + {1'b0, lo_reg};
    assign hi_n     = (ev_res < mid_reg) ? mid_reg : hi_reg;
    assign lo_n     = (ev_res < mid_reg) ? lo_reg : mid_reg;
    assign gap_n    = (hi_n > lo_n) ? hi_n - lo_n : lo_n - hi_n;
    assign loop_lhs = 37'(gap_n) * 37'(LOOP_TOL);
    assign unconv   = loop_lhs > 37'(mid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid   <= 1'b0;
            num_reg   <= '0;
        end else begin
            if (out_load) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        flux_reg  <= q_data.flux;
                        t0_reg    <= q_data.temp;
                        num_reg   <= '1;    // marks the first evaluation as not yet started
                        state_reg <= ST_WAIT0;
                    end
                end
                ST_WAIT0: begin
                    if (num_reg == '1) begin
                        num_reg <= '0;
                    end else if (ev_done) begin
                        hi_reg  <= hi0;
                        lo_reg  <= lo0;
                        res_reg <= t0_reg;
                        hit_reg <= 1'b0;
                        state_reg <= (init_lhs > 30'(t1)) ? ST_STEP : ST_OUT;
                    end
                end
                ST_STEP: begin
                    mid_reg   <= mid_sum[TEMP_W:1];
                    state_reg <= ST_WAITM;
                end
                ST_WAITM: begin
                    if (ev_done) begin
                        hi_reg  <= hi_n;
                        lo_reg  <= lo_n;
                        res_reg <= mid_reg;
                        num_reg <= num_reg + ITER_W'(1);
                        hit_reg <= unconv;
                        if (!unconv || num_reg == ITER_W'(MAX_ITERATIONS - 1)) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_STEP;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_new_temp        <= res_reg;
                        m_iterations_used <= num_reg;
                        m_hit_limit       <= hit_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/wall_temp_bisection_solver.sv
`default_nettype none
// an item takes one face evaluation, plus one more per bisection step, with at most MAX_ITERATIONS steps
// a face evaluation runs its quotient through a bit-serial divider, except
// when the conducted rise saturates and the divider is skipped
// throughput: one item at a time in the solver, the input queue holds two more
// and the result register lets the next item start while a result waits
// reset: synchronous active-low aresetn clears control state and loads config defaults
module wall_temp_bisection_solver #(
    parameter int MAX_ITERATIONS = 50
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [wtbs_pkg::CIDX_W-1:0]        cfg_index,
    input  wire  [wtbs_pkg::CDATA_W-1:0]       cfg_wr_data,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  signed [wtbs_pkg::FLUX_W-1:0] s_incident_flux,
    input  wire  [wtbs_pkg::TEMP_W-1:0]        s_old_temp,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [wtbs_pkg::TEMP_W-1:0]        m_new_temp,
    output logic [wtbs_pkg::ITER_W-1:0]        m_iterations_used,
    output logic                               m_hit_limit
);
    import wtbs_pkg::*;

    cfg_t  cfg_reg;
    item_t in_item, q_data;
    logic  q_full, q_empty, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.conductivity      <= 16'd256;
            cfg_reg.wall_thickness_um <= 20'd10000;
            cfg_reg.tube_side_temp    <= 20'd95744;
            cfg_reg.max_wall_temp     <= 20'd768000;
            cfg_reg.min_wall_temp     <= 20'd95488;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CONDUCTIVITY: cfg_reg.conductivity      <= cfg_wr_data[K_W-1:0];
                REG_THICKNESS:    cfg_reg.wall_thickness_um <= cfg_wr_data;
                REG_TUBE_TEMP:    cfg_reg.tube_side_temp    <= cfg_wr_data;
                REG_MAX_TEMP:     cfg_reg.max_wall_temp     <= cfg_wr_data;
                REG_MIN_TEMP:     cfg_reg.min_wall_temp     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign s_ready      = !q_full;
    assign in_item.flux = s_incident_flux;
    assign in_item.temp = s_old_temp;

    wtbs_fifo u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_valid && s_ready),
        .wr_data (in_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    wtbs_engine #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_engine (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .q_empty           (q_empty),
        .q_data            (q_data),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_new_temp        (m_new_temp),
        .m_iterations_used (m_iterations_used),
        .m_hit_limit       (m_hit_limit)
    );
endmodule
`default_nettype wire
